// ===== hdl/srtf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtf_pkg
// Shared widths, types and defaults for the SRTF scheduler.
// ----------------------------------------------------------------------------
package srtf_pkg;

  localparam int unsigned MaxProcessesDef = 16;
  localparam int unsigned DataW           = 16;  // arrival / burst / remaining
  localparam int unsigned TimeW           = 23;  // simulation tick
  localparam int unsigned JobIdxW         = 6;   // job_index port width

  // One RAM word per job.
  typedef struct packed {
    logic [DataW-1:0] arrival;
    logic [DataW-1:0] burst;
    logic [DataW-1:0] remaining;
  } job_t;

  localparam int unsigned JobW = $bits(job_t);

  // Completion request from the controller to the result stage.
  typedef struct packed {
    logic               valid;
    logic [JobIdxW-1:0] idx;
    logic [TimeW-1:0]   completion;
    logic [DataW-1:0]   arrival;
    logic [DataW:0]     arr_bur;  // arrival + burst
    logic               last;
  } res_req_t;

endpackage

// ===== hdl/srtf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srtf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/srtf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtf_ctrl
// Job loader and event-driven SRTF sequencer over the job RAM.
// ----------------------------------------------------------------------------
module srtf_ctrl
  import srtf_pkg::*;
#(
  parameter int unsigned MaxProcesses = MaxProcessesDef,
  localparam int unsigned IdxW = (MaxProcesses > 1) ? $clog2(MaxProcesses) : 1,
  localparam int unsigned CntW = $clog2(MaxProcesses + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic [DataW-1:0] arrival_i,
  input  logic [DataW-1:0] burst_i,
  input  logic             last_job_i,
  output logic             busy,
  // RAM port
  output logic             ram_we_o,
  output logic [IdxW-1:0]  ram_waddr_o,
  output job_t             ram_wdata_o,
  output logic [IdxW-1:0]  ram_raddr_o,
  input  job_t             ram_rdata_i,
  // completion request
  output res_req_t         res_o
);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StUpdate
  } state_e;

  state_e           state_q, state_d;
  logic [CntW-1:0]  job_cnt_q, job_cnt_d;
  logic [CntW-1:0]  done_cnt_q, done_cnt_d;
  logic [TimeW-1:0] time_q, time_d;
  logic [CntW-1:0]  scan_cnt_q, scan_cnt_d;
  logic             rd_vld_q, rd_vld_d;
  logic [CntW-1:0]  rd_idx_q, rd_idx_d;
  // scan accumulators
  logic             found_q, found_d;
  logic [IdxW-1:0]  pick_q, pick_d;
  logic [DataW-1:0] best_rem_q, best_rem_d;
  logic [DataW-1:0] pick_arr_q, pick_arr_d;
  logic [DataW-1:0] pick_bur_q, pick_bur_d;
  logic             have_next_q, have_next_d;
  logic [DataW-1:0] next_arr_q, next_arr_d;

  logic [DataW-1:0] bur_sat;
  logic [TimeW-1:0] gap;
  logic [DataW-1:0] run_len;
  logic [DataW-1:0] new_rem;
  logic [TimeW-1:0] time_run;

  assign busy        = (state_q != StIdle);
  assign ram_raddr_o = scan_cnt_q[IdxW-1:0];
  assign bur_sat     = (burst_i == '0) ? DataW'(1) : burst_i;

  // run until the pick finishes or the next arrival, whichever is first
  assign gap      = TimeW'(next_arr_q) - time_q;
  assign run_len  = (have_next_q && (gap < TimeW'(best_rem_q))) ? gap[DataW-1:0] : best_rem_q;
  assign new_rem  = best_rem_q - run_len;
  assign time_run = time_q + TimeW'(run_len);

  always_comb begin
    state_d     = state_q;
    job_cnt_d   = job_cnt_q;
    done_cnt_d  = done_cnt_q;
    time_d      = time_q;
    scan_cnt_d  = scan_cnt_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    found_d     = found_q;
    pick_d      = pick_q;
    best_rem_d  = best_rem_q;
    pick_arr_d  = pick_arr_q;
    pick_bur_d  = pick_bur_q;
    have_next_d = have_next_q;
    next_arr_d  = next_arr_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = job_cnt_q[IdxW-1:0];
    ram_wdata_o = '{arrival: arrival_i, burst: bur_sat, remaining: bur_sat};
    res_o       = '{valid: 1'b0, idx: JobIdxW'(pick_q), completion: time_run,
                    arrival: pick_arr_q,
                    arr_bur: (DataW+1)'(pick_arr_q) + (DataW+1)'(pick_bur_q),
                    last: 1'b0};

    unique case (state_q)
      StIdle: begin
        if (start) begin
          if (job_cnt_q < CntW'(MaxProcesses)) begin
            ram_we_o  = 1'b1;
            job_cnt_d = job_cnt_q + CntW'(1);
          end
          if (last_job_i) begin
            state_d     = StScan;
            time_d      = '0;
            done_cnt_d  = '0;
            scan_cnt_d  = '0;
            found_d     = 1'b0;
            have_next_d = 1'b0;
          end
        end
      end

      StScan: begin
        if (scan_cnt_q < job_cnt_q) begin
          rd_vld_d   = 1'b1;
          rd_idx_d   = scan_cnt_q;
          scan_cnt_d = scan_cnt_q + CntW'(1);
        end
        if (rd_vld_q) begin
          if (ram_rdata_i.remaining != '0) begin
            if (TimeW'(ram_rdata_i.arrival) <= time_q) begin
              if (!found_q || (ram_rdata_i.remaining < best_rem_q)) begin
                found_d    = 1'b1;
                pick_d     = rd_idx_q[IdxW-1:0];
                best_rem_d = ram_rdata_i.remaining;
                pick_arr_d = ram_rdata_i.arrival;
                pick_bur_d = ram_rdata_i.burst;
              end
            end else if (!have_next_q || (ram_rdata_i.arrival < next_arr_q)) begin
              have_next_d = 1'b1;
              next_arr_d  = ram_rdata_i.arrival;
            end
          end
          if (rd_idx_q == job_cnt_q - CntW'(1)) begin
            state_d = StUpdate;
          end
        end
      end

      StUpdate: begin
        state_d     = StScan;
        scan_cnt_d  = '0;
        found_d     = 1'b0;
        have_next_d = 1'b0;
        if (!found_q) begin
          // idle ticks up to the next arrival
          time_d = TimeW'(next_arr_q);
        end else begin
          time_d      = time_run;
          ram_we_o    = 1'b1;
          ram_waddr_o = pick_q;
          ram_wdata_o = '{arrival: pick_arr_q, burst: pick_bur_q, remaining: new_rem};
          if (new_rem == '0) begin
            res_o.valid = 1'b1;
            done_cnt_d  = done_cnt_q + CntW'(1);
            if (done_cnt_q + CntW'(1) == job_cnt_q) begin
              res_o.last = 1'b1;
              state_d    = StIdle;
              job_cnt_d  = '0;
              done_cnt_d = '0;
              time_d     = '0;
            end
          end
        end
      end

      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      job_cnt_q   <= '0;
      done_cnt_q  <= '0;
      time_q      <= '0;
      scan_cnt_q  <= '0;
      rd_vld_q    <= 1'b0;
      rd_idx_q    <= '0;
      found_q     <= 1'b0;
      pick_q      <= '0;
      best_rem_q  <= '0;
      pick_arr_q  <= '0;
      pick_bur_q  <= '0;
      have_next_q <= 1'b0;
      next_arr_q  <= '0;
    end else begin
      state_q     <= state_d;
      job_cnt_q   <= job_cnt_d;
      done_cnt_q  <= done_cnt_d;
      time_q      <= time_d;
      scan_cnt_q  <= scan_cnt_d;
      rd_vld_q    <= rd_vld_d;
      rd_idx_q    <= rd_idx_d;
      found_q     <= found_d;
      pick_q      <= pick_d;
      best_rem_q  <= best_rem_d;
      pick_arr_q  <= pick_arr_d;
      pick_bur_q  <= pick_bur_d;
      have_next_q <= have_next_d;
      next_arr_q  <= next_arr_d;
    end
  end

endmodule

// ===== hdl/srtf_result.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtf_result
// Two-stage result pipe: captures a completion, then forms turnaround and
// waiting times and drives the one-cycle result strobe.
// ----------------------------------------------------------------------------
module srtf_result
  import srtf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  res_req_t           res_i,
  output logic               done_o,
  output logic [JobIdxW-1:0] job_index_o,
  output logic [TimeW-1:0]   completion_o,
  output logic [TimeW-1:0]   turnaround_o,
  output logic [TimeW-1:0]   waiting_o,
  output logic               last_result_o
);

  res_req_t pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      done_o <= 1'b0;
    end else begin
      pend_q <= res_i;
      done_o <= pend_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    job_index_o   <= pend_q.idx;
    completion_o  <= pend_q.completion;
    turnaround_o  <= pend_q.completion - TimeW'(pend_q.arrival);
    waiting_o     <= pend_q.completion - TimeW'(pend_q.arr_bur);
    last_result_o <= pend_q.last;
  end

endmodule

// ===== hdl/srtf_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtf_scheduler
// Preemptive shortest-remaining-time-first scheduler over a job RAM.
// ----------------------------------------------------------------------------
// Loading: one job per cycle, busy stays low until the last_job request.
// Run: one pass over the job RAM per event (arrival or preemption/finish),
//   reading one loaded job at a time, since the RAM has one read port; a run
//   takes at most about 2N passes. Result strobes are registered in srtf_result.
// Results cannot be stalled: done_o is high for exactly one cycle each.
// Reset (rst_ni low, async) empties the job set; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module srtf_scheduler
  import srtf_pkg::*;
#(
  parameter int unsigned MAX_PROCESSES = MaxProcessesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request side
  input  logic               start,
  output logic               busy,
  input  logic [DataW-1:0]   arrival_i,
  input  logic [DataW-1:0]   burst_i,
  input  logic               last_job_i,
  // result side
  output logic               done_o,
  output logic [JobIdxW-1:0] job_index_o,
  output logic [TimeW-1:0]   completion_o,
  output logic [TimeW-1:0]   turnaround_o,
  output logic [TimeW-1:0]   waiting_o,
  output logic               last_result_o
);

  localparam int unsigned IdxW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;

  // Job RAM: one word per job, {arrival, burst, remaining}. The sequencer
  // reads every loaded entry per pass and writes back only the picked job.
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  job_t            ram_wdata;
  logic [IdxW-1:0] ram_raddr;
  job_t            ram_rdata;
  res_req_t        res_req;

  srtf_ram #(
    .Width (JobW),
    .Depth (MAX_PROCESSES)
  ) u_job_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Loader and scheduler: min-remaining search among arrived jobs (ties to
  // lowest index) plus nearest future arrival, then one run/idle step.
  srtf_ctrl #(
    .MaxProcesses (MAX_PROCESSES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .arrival_i   (arrival_i),
    .burst_i     (burst_i),
    .last_job_i  (last_job_i),
    .busy        (busy),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .res_o       (res_req)
  );

  // Turnaround and waiting times, registered onto the result ports.
  srtf_result u_result (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_i         (res_req),
    .done_o        (done_o),
    .job_index_o   (job_index_o),
    .completion_o  (completion_o),
    .turnaround_o  (turnaround_o),
    .waiting_o     (waiting_o),
    .last_result_o (last_result_o)
  );

endmodule
